[design/slpst_pkg.sv]
// shared types and constants of the scatter list partial send tracker
package slpst_pkg;

  // fixed field widths
  localparam int MOVED_W     = 21;
  localparam int SUM_W       = 20;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 4;
  localparam int NEXT_SLOT_W = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // command codes carried in tuser
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_OVER = 2'd2,
    STAT_NONE = 2'd3
  } status_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WALK_RD,
    ST_WALK_WB,
    ST_SNAP_RD,
    ST_SNAP
  } state_e;

endpackage

[design/slpst_ram.sv]
// generic single write port ram with registered read
module slpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/scatter_list_partial_send_tracker_top.sv]
// top level of the scatter list partial send tracker
//
//  channel  | group        | beat carries
//  ---------+--------------+---------------------------------------------------
//  input    | s_axis_*     | tuser: cmd; tdata: seg_addr, seg_len, moved_bytes
//  output   | m_axis_*     | tuser: status; tdata: slot_index .. grand_size
//
// an append goes from accept through eval, snapshot read and snapshot to its
// result; a report walks the table between eval and snapshot read, with one
// read and one write back per entry on the single segment ram port pair, and
// a last walk read when the walk reaches the end of the filled entries.
// reset clears the counters and sums at once, the segment ram is not cleared.
// a new beat is taken once the previous one has moved into the output
// register; a stalled output only holds the next result in its last step.
module scatter_list_partial_send_tracker_top #(
  parameter int SEGMENTS  = 16,
  parameter int ADDR_BITS = 32,
  parameter int LEN_BITS  = 16,
  localparam int IN_DATA_W  = ((ADDR_BITS + LEN_BITS + 21 + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((4 + 21 + 1 + 5 + ADDR_BITS + LEN_BITS + 20 + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // seg_addr, seg_len, moved_bytes
  input  logic [IN_DATA_W-1:0]      s_axis_tdata_i,
  // cmd
  input  logic                      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  // slot_index, result_bytes, all_sent, next_slot, next_addr, next_len, grand_size
  output logic [OUT_DATA_W-1:0]     m_axis_tdata_o,
  // status
  output logic [slpst_pkg::STATUS_W-1:0] m_axis_tuser_o
);

  import slpst_pkg::*;

  localparam int CNT_W  = $clog2(SEGMENTS + 1);
  localparam int IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int ENT_W  = ADDR_BITS + LEN_BITS;
  localparam int CMP_W  = (LEN_BITS > SUM_W) ? LEN_BITS : SUM_W;
  localparam int SZ_W   = CMP_W + 1;
  localparam int AX_W   = (ADDR_BITS > SUM_W) ? ADDR_BITS : SUM_W;
  localparam int LEN_LO = ADDR_BITS;
  localparam int MOV_LO = ADDR_BITS + LEN_BITS;

  // control state
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [CNT_W-1:0]     start_q, start_d;
  logic [SUM_W-1:0]     size_q, size_d;
  logic [SUM_W-1:0]     sent_q, sent_d;
  logic                 out_valid_q, out_valid_d;

  // item and walk registers
  logic                 cmd_q;
  logic [ADDR_BITS-1:0] in_addr_q;
  logic [LEN_BITS-1:0]  in_len_q;
  logic [MOVED_W-1:0]   moved_q;
  status_e              status_q, status_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [MOVED_W-1:0]   result_q, result_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic                 hit_q, hit_d;
  logic [OUT_DATA_W-1:0]     out_data_q;
  logic [STATUS_W-1:0]  out_user_q;
  logic                 out_load;

  // ram ports
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]     ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [LEN_BITS-1:0]  rd_len;

  // evaluation terms
  logic                 accept_in, out_free, nothing, over, full, len_short;
  logic [SUM_W-1:0]     raw_mag, remaining, sent_add;
  logic [SZ_W-1:0]      size_add;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept_in       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign rd_addr = ram_rdata[ADDR_BITS-1:0];
  assign rd_len  = ram_rdata[ENT_W-1:ADDR_BITS];

  // report and append arithmetic
  assign raw_mag   = moved_q[SUM_W-1:0];
  assign nothing   = (moved_q == '0) || moved_q[MOVED_W-1];
  assign remaining = (size_q >= sent_q) ? (size_q - sent_q) : '0;
  assign over      = raw_mag > remaining;
  assign sent_add  = sent_q + raw_mag;
  assign full      = used_q >= CNT_W'(SEGMENTS);
  assign size_add  = SZ_W'(size_q) + SZ_W'(in_len_q);
  assign len_short = CMP_W'(rd_len) < CMP_W'(rem_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept_in) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (cmd_q == CMD_REPORT && !nothing && !over && sent_add != size_q) begin
          state_d = ST_WALK_RD;
        end else begin
          state_d = ST_SNAP_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = (idx_q < used_q) ? ST_WALK_WB : ST_SNAP_RD;
      end
      ST_WALK_WB: begin
        state_d = len_short ? ST_WALK_RD : ST_SNAP_RD;
      end
      ST_SNAP_RD: state_d = ST_SNAP;
      ST_SNAP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    used_d      = used_q;
    start_d     = start_q;
    size_d      = size_q;
    sent_d      = sent_q;
    status_d    = status_q;
    slot_d      = slot_q;
    result_d    = result_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    hit_d       = hit_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = idx_q[IDX_W-1:0];
    ram_raddr   = idx_q[IDX_W-1:0];
    ram_wdata   = {rd_len, rd_addr};
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      ST_EVAL: begin
        slot_d = '0;
        if (cmd_q == CMD_APPEND) begin
          result_d = MOVED_W'(sent_q);
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            status_d  = STAT_OK;
            slot_d    = SLOT_W'(used_q);
            ram_we    = 1'b1;
            ram_waddr = used_q[IDX_W-1:0];
            ram_wdata = {in_len_q, in_addr_q};
            used_d    = used_q + 1'b1;
            size_d    = (size_add > SZ_W'(SUM_MAX)) ? SUM_MAX : size_add[SUM_W-1:0];
          end
        end else if (nothing) begin
          status_d = STAT_NONE;
          result_d = moved_q;
        end else if (over) begin
          status_d = STAT_OVER;
          sent_d   = size_q;
          result_d = MOVED_W'(size_q);
        end else begin
          status_d = STAT_OK;
          sent_d   = sent_add;
          result_d = MOVED_W'(sent_add);
          idx_d    = start_q;
          rem_d    = raw_mag;
        end
      end
      ST_WALK_RD: begin
        ram_re = idx_q < used_q;
      end
      ST_WALK_WB: begin
        ram_we = 1'b1;
        if (len_short) begin
          // whole segment sent
          ram_wdata = {{LEN_BITS{1'b0}}, rd_addr};
          rem_d     = SUM_W'(CMP_W'(rem_q) - CMP_W'(rd_len));
          idx_d     = idx_q + 1'b1;
        end else begin
          // partly or exactly sent segment ends the walk
          ram_wdata = {LEN_BITS'(CMP_W'(rd_len) - CMP_W'(rem_q)),
                       ADDR_BITS'(AX_W'(rd_addr) + AX_W'(rem_q))};
          start_d   = (CMP_W'(rd_len) != CMP_W'(rem_q)) ? idx_q : idx_q + 1'b1;
        end
      end
      ST_SNAP_RD: begin
        hit_d     = start_q < used_q;
        ram_re    = start_q < used_q;
        ram_raddr = start_q[IDX_W-1:0];
      end
      ST_SNAP: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      start_q     <= '0;
      size_q      <= '0;
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      start_q     <= start_d;
      size_q      <= size_d;
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q     <= s_axis_tuser_i;
      in_addr_q <= s_axis_tdata_i[ADDR_BITS-1:0];
      in_len_q  <= s_axis_tdata_i[MOV_LO-1:LEN_LO];
      moved_q   <= s_axis_tdata_i[MOV_LO+MOVED_W-1:MOV_LO];
    end
    status_q <= status_d;
    slot_q   <= slot_d;
    result_q <= result_d;
    idx_q    <= idx_d;
    rem_q    <= rem_d;
    hit_q    <= hit_d;
    if (out_load) begin
      out_user_q <= status_q;
      out_data_q <= OUT_DATA_W'({size_q,
                                 hit_q ? rd_len : {LEN_BITS{1'b0}},
                                 hit_q ? rd_addr : {ADDR_BITS{1'b0}},
                                 NEXT_SLOT_W'(start_q),
                                 sent_q == size_q,
                                 result_q,
                                 slot_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // segment table, address in the low bits and remaining length above
  slpst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SEGMENTS)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  // the sent total never passes the appended size
  assert property (@(posedge clk_i) disable iff (!rst_ni) sent_q <= size_q)
    else $error("sent total exceeds total size");

  // the start slot never moves past the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_q <= used_q)
    else $error("start slot beyond used slots");

  // a write back only follows a read of a filled entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_WB) |-> (idx_q < used_q) && $past(ram_re))
    else $error("walk write back without a valid read");
`endif

endmodule
